// File: sv/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Types and constants shared by the RTP/H.264 header parser modules.
// ----------------------------------------------------------------------------
package rhp_pkg;

  // Fixed RTP header length in bytes.
  localparam int unsigned HDR_BYTES = 12;

  // H.264 NAL unit types handled by the parser.
  localparam logic [4:0] NAL_STAP_A = 5'd24;
  localparam logic [4:0] NAL_FU_A   = 5'd28;

  // Saturation value of the STAP-A unit offset.
  localparam logic [16:0] AGG_LIMIT = 17'h1FFFF;

  // Byte queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified byte as the front part hands it to the back part.
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [15:0] offset;
    logic        in_window;
  } rhp_entry_t;

  // Queue status seen by the front part.
  typedef struct packed {
    logic full;
  } rhp_q_status_t;

  // Packet summary held in the output register.
  typedef struct packed {
    logic        status;
    logic [6:0]  payload_type;
    logic        marker;
    logic [15:0] sequence_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [3:0]  csrc_count;
    logic        has_extension;
    logic [15:0] packet_length;
    logic [4:0]  nal_type;
    logic [4:0]  sub_nal_type;
    logic [1:0]  fu_start_end;
  } rhp_result_t;

endpackage

// File: sv/rhp_if.sv
// ----------------------------------------------------------------------------
// rhp_if
// Valid/ready stream interfaces for packet bytes and packet summaries.
// ----------------------------------------------------------------------------
interface rhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhp_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  payload_type;
  logic        marker;
  logic [15:0] sequence_number;
  logic [31:0] time_stamp;
  logic [31:0] source_id;
  logic [3:0]  csrc_count;
  logic        has_extension;
  logic [15:0] packet_length;
  logic [4:0]  nal_type;
  logic [4:0]  sub_nal_type;
  logic [1:0]  fu_start_end;

  modport source (
    output valid, input ready,
    output status, output payload_type, output marker, output sequence_number,
    output time_stamp, output source_id, output csrc_count, output has_extension,
    output packet_length, output nal_type, output sub_nal_type, output fu_start_end
  );
  modport sink (
    input valid, output ready,
    input status, input payload_type, input marker, input sequence_number,
    input time_stamp, input source_id, input csrc_count, input has_extension,
    input packet_length, input nal_type, input sub_nal_type, input fu_start_end
  );
endinterface

// File: sv/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// Accepts packet bytes, tags each with its offset and parse window flag.
// ----------------------------------------------------------------------------
module rhp_front
  import rhp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic          clk,
  input  logic          rst_n,
  rhp_in_if.sink        in_bus,
  input  rhp_q_status_t q_status,
  output logic          push,
  output rhp_entry_t    push_entry
);

  logic [15:0] offset_r;
  logic [15:0] offset_nxt;

  // A byte is taken whenever the queue has room.
  assign in_bus.ready = !q_status.full;
  assign push         = in_bus.valid && in_bus.ready;

  assign push_entry.data      = in_bus.data_byte;
  assign push_entry.last      = in_bus.last_byte;
  assign push_entry.offset    = offset_r;
  assign push_entry.in_window = offset_r < 16'(MAX_PACKET_BYTES);

  // Byte offset saturates and restarts after the final byte of a packet.
  always_comb begin
    offset_nxt = offset_r;
    if (push) begin
      if (in_bus.last_byte) begin
        offset_nxt = '0;
      end else if (offset_r != 16'hFFFF) begin
        offset_nxt = offset_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
    end else begin
      offset_r <= offset_nxt;
    end
  end

endmodule

// File: sv/rhp_queue.sv
// ----------------------------------------------------------------------------
// rhp_queue
// Short first-in first-out queue of classified bytes.
// ----------------------------------------------------------------------------
module rhp_queue
  import rhp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rhp_entry_t    push_entry,
  output rhp_q_status_t q_status,
  output logic          pop_valid,
  output rhp_entry_t    pop_entry,
  input  logic          pop
);

  rhp_entry_t          slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic [QPTR_W:0]     count_nxt;

  assign q_status.full = count_r == (QPTR_W + 1)'(QUEUE_DEPTH);
  assign pop_valid     = count_r != '0;
  assign pop_entry     = slots_r[rd_ptr_r];

  // Fill level follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && pop_valid)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && pop_valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Entry storage has no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && pop_valid) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// File: sv/rhp_back.sv
// ----------------------------------------------------------------------------
// rhp_back
// Parses queued bytes into RTP and NAL fields and holds the packet summary.
// ----------------------------------------------------------------------------
module rhp_back
  import rhp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  input  rhp_entry_t pop_entry,
  output logic       pop,
  rhp_out_if.source  out_bus
);

  logic [7:0]  hb_r [HDR_BYTES];
  logic [7:0]  hb_nxt [HDR_BYTES];
  logic [18:0] ps_r, ps_nxt;
  logic [7:0]  ext_hi_r, ext_hi_nxt;
  logic [4:0]  nal_r, nal_nxt;
  logic [1:0]  fu_r, fu_nxt;
  logic [16:0] agg_r, agg_nxt;
  logic [4:0]  sub_r, sub_nxt;
  logic [23:0] recent_r, recent_nxt;

  logic        out_valid_r, out_valid_nxt;
  rhp_result_t res_r, res_nxt;

  logic [15:0] o;
  logic [7:0]  b;
  logic [6:0]  ext_base;
  logic [17:0] agg_sum;
  logic [15:0] unit_size;
  logic [15:0] pkt_len;
  logic [15:0] eff_len;
  logic        too_short;
  logic        pop_last;

  assign o = pop_entry.offset;
  assign b = pop_entry.data;

  // The final byte waits only while the summary register is full and out_bus stalls.
  assign pop      = pop_valid && (!pop_entry.last || !out_valid_r || out_bus.ready);
  assign pop_last = pop && pop_entry.last;

  assign ext_base  = 7'd12 + {1'b0, hb_r[0][3:0], 2'b00};
  assign unit_size = recent_r[23:8];
  assign agg_sum   = {1'b0, agg_r} + 18'd2 + {2'b00, unit_size};

  // Per-byte parse of header, extension, NAL and aggregation fields.
  always_comb begin
    hb_nxt     = hb_r;
    ps_nxt     = ps_r;
    ext_hi_nxt = ext_hi_r;
    nal_nxt    = nal_r;
    fu_nxt     = fu_r;
    agg_nxt    = agg_r;
    sub_nxt    = sub_r;
    recent_nxt = recent_r;
    if (pop && pop_entry.in_window) begin
      if (o < 16'(HDR_BYTES)) begin
        hb_nxt[o[3:0]] = b;
        if (o == 16'd0) begin
          ps_nxt = 19'd12 + {13'd0, b[3:0], 2'b00} + (b[4] ? 19'd4 : 19'd0);
        end
      end
      if (hb_r[0][4]) begin
        if (o == {9'd0, ext_base} + 16'd2) begin
          ext_hi_nxt = b;
        end else if (o == {9'd0, ext_base} + 16'd3) begin
          ps_nxt = ps_r + {1'b0, ext_hi_r, b, 2'b00};
        end
      end
      if ({3'b000, o} == ps_r) begin
        nal_nxt = b[4:0];
        if (b[4:0] == NAL_STAP_A) begin
          agg_nxt = {1'b0, o} + 17'd1;
        end
      end else if ({3'b000, o} > ps_r) begin
        if (nal_r == NAL_FU_A && {4'b0000, o} == {1'b0, ps_r} + 20'd1) begin
          sub_nxt = b[4:0];
          fu_nxt  = {b[7], b[6]};
        end else if (nal_r == NAL_STAP_A && {2'b00, o} == {1'b0, agg_r} + 18'd3) begin
          sub_nxt = recent_r[4:0];
          agg_nxt = (agg_sum > {1'b0, AGG_LIMIT}) ? AGG_LIMIT : agg_sum[16:0];
        end
      end
      recent_nxt = {recent_r[15:0], b};
    end
  end

  // Summary built from the state as it stands after the final byte.
  always_comb begin
    pkt_len   = (o == 16'hFFFF) ? o : o + 16'd1;
    eff_len   = (pkt_len < 16'(MAX_PACKET_BYTES)) ? pkt_len : 16'(MAX_PACKET_BYTES);
    too_short = {3'b000, eff_len} <= ps_nxt;

    res_nxt.status          = too_short;
    res_nxt.payload_type    = hb_nxt[1][6:0];
    res_nxt.marker          = hb_nxt[1][7];
    res_nxt.sequence_number = {hb_nxt[2], hb_nxt[3]};
    res_nxt.time_stamp      = {hb_nxt[4], hb_nxt[5], hb_nxt[6], hb_nxt[7]};
    res_nxt.source_id       = {hb_nxt[8], hb_nxt[9], hb_nxt[10], hb_nxt[11]};
    res_nxt.csrc_count      = hb_nxt[0][3:0];
    res_nxt.has_extension   = hb_nxt[0][4];
    res_nxt.packet_length   = pkt_len;
    if (too_short) begin
      res_nxt.nal_type     = '0;
      res_nxt.sub_nal_type = '0;
      res_nxt.fu_start_end = '0;
    end else begin
      res_nxt.nal_type     = nal_nxt;
      res_nxt.sub_nal_type = (nal_nxt == NAL_STAP_A || nal_nxt == NAL_FU_A) ? sub_nxt : 5'd0;
      res_nxt.fu_start_end = (nal_nxt == NAL_FU_A) ? fu_nxt : 2'd0;
    end

    out_valid_nxt = out_valid_r && !out_bus.ready;
    if (pop_last) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Parse state, cleared at reset and after every packet.
  always_ff @(posedge clk) begin
    if (!rst_n || pop_last) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        hb_r[i] <= '0;
      end
      ps_r     <= 19'd12;
      ext_hi_r <= '0;
      nal_r    <= '0;
      fu_r     <= '0;
      agg_r    <= '0;
      sub_r    <= '0;
      recent_r <= '0;
    end else begin
      hb_r     <= hb_nxt;
      ps_r     <= ps_nxt;
      ext_hi_r <= ext_hi_nxt;
      nal_r    <= nal_nxt;
      fu_r     <= fu_nxt;
      agg_r    <= agg_nxt;
      sub_r    <= sub_nxt;
      recent_r <= recent_nxt;
    end
  end

  // Summary output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = res_r.status;
  assign out_bus.payload_type    = res_r.payload_type;
  assign out_bus.marker          = res_r.marker;
  assign out_bus.sequence_number = res_r.sequence_number;
  assign out_bus.time_stamp      = res_r.time_stamp;
  assign out_bus.source_id       = res_r.source_id;
  assign out_bus.csrc_count      = res_r.csrc_count;
  assign out_bus.has_extension   = res_r.has_extension;
  assign out_bus.packet_length   = res_r.packet_length;
  assign out_bus.nal_type        = res_r.nal_type;
  assign out_bus.sub_nal_type    = res_r.sub_nal_type;
  assign out_bus.fu_start_end    = res_r.fu_start_end;

  // A final byte always leaves a summary waiting in the next cycle.
  a_last_gives_summary: assert property (@(posedge clk) disable iff (!rst_n)
    pop_last |=> out_valid_r)
    else $error("final byte did not produce a summary");

  // The payload start is back at the fixed header length after each packet.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    pop_last |=> ps_r == 19'd12 && nal_r == 5'd0 && sub_r == 5'd0)
    else $error("parse state not cleared after packet");

  // A too-short summary carries no NAL information.
  a_short_no_nal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.status |->
      res_r.nal_type == 5'd0 && res_r.sub_nal_type == 5'd0 && res_r.fu_start_end == 2'd0)
    else $error("too-short summary reports NAL fields");

  // A final byte is never retired while the summary register is full and stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |-> !pop_last)
    else $error("summary overwritten while stalled");

endmodule

// File: sv/rtp_h264_header_parser_core.sv
// ----------------------------------------------------------------------------
// rtp_h264_header_parser_core
// RTP header and H.264 NAL type parser, one packet byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries the packet one byte per transfer, with last_byte set on the
//   final byte. out_bus carries one summary per packet: RTP header fields,
//   packet length, NAL type, the STAP-A last unit type or FU-A type and the
//   FU-A start/end flags, and a status bit for packets not longer than the
//   header.
//   Throughput: one byte per cycle across packet boundaries while out_bus
//   does not stall; the front part takes a byte whenever the four-entry
//   byte queue has room and the back part retires one queued byte per cycle.
//   The final byte passes through the byte queue, and the summary is then
//   loaded into the summary register, from which out_bus.valid is driven.
//   When out_bus stalls, the summary is held; bytes of the next packet keep
//   flowing until its final byte reaches the back part, which then waits for
//   the summary register to free up, after which the queue fills and
//   in_bus.ready drops.
//   Reset (rst_n low, synchronous) empties the queue, drops any pending
//   summary and returns all parse state to the start of a packet.
// ----------------------------------------------------------------------------
module rtp_h264_header_parser_core
  import rhp_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  rhp_in_if.sink    in_bus,
  rhp_out_if.source out_bus
);

  rhp_q_status_t q_status;
  logic          push;
  rhp_entry_t    push_entry;
  logic          pop_valid;
  rhp_entry_t    pop_entry;
  logic          pop;

  // Front part: byte acceptance and offset tagging.
  rhp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .q_status  (q_status),
    .push      (push),
    .push_entry(push_entry)
  );

  // Queue between front and back.
  rhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .q_status  (q_status),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop)
  );

  // Back part: field parsing and summary register.
  rhp_back #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop_valid(pop_valid),
    .pop_entry(pop_entry),
    .pop      (pop),
    .out_bus  (out_bus)
  );

endmodule
